@@ design/dit_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dit_pkg: shared types and constants for the directional index tracker
// Widths, fixed-point formats, sequencer states and the command and status
// records exchanged with the shared step unit.
// ----------------------------------------------------------------------------
package dit_pkg;

  // Price and average formats
  localparam int PRICE_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int AVG_BITS   = PRICE_BITS + FRAC_BITS;

  // Smoothing weight, unsigned Q1.16 so 1.0 fits
  localparam int ALPHA_FRAC = 16;
  localparam int ALPHA_BITS = ALPHA_FRAC + 1;

  // Indicator formats: DI in Q7.8, DX and index average in Q7.16
  localparam int OUT_BITS   = 15;
  localparam int DI_BITS    = 15;
  localparam int SUM_BITS   = DI_BITS + 1;
  localparam int INDEX_FRAC = 16;
  localparam int DX_BITS    = 23;

  // Blend datapath holds whichever of the averages is wider
  localparam int BLEND_BITS = (AVG_BITS > DX_BITS) ? AVG_BITS : DX_BITS;
  localparam int ACC_BITS   = BLEND_BITS + ALPHA_FRAC + 3;

  // Dividends: avg * 25600 and diff * 100 * 2^16
  localparam int DI_DVD_BITS = AVG_BITS + DI_BITS;
  localparam int HUND_BITS   = DI_BITS + 7;
  localparam int DX_DVD_BITS = HUND_BITS + INDEX_FRAC;

  // Step unit shift register and step counter
  localparam int SEL_BITS = (DX_BITS > ALPHA_BITS) ? DX_BITS : ALPHA_BITS;
  localparam int CNT_BITS = 5;

  localparam logic [CNT_BITS-1:0] BLEND_STEPS = CNT_BITS'(ALPHA_BITS);
  localparam logic [CNT_BITS-1:0] DI_STEPS    = CNT_BITS'(DI_BITS);
  localparam logic [CNT_BITS-1:0] DX_STEPS    = CNT_BITS'(DX_BITS);

  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE   = ALPHA_BITS'(65536);
  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = ALPHA_BITS'(8738);
  localparam logic [DI_BITS-1:0]    DI_FULL     = DI_BITS'(25600);

  // Configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_IDX_BITS  = CFG_ADDR_BITS - 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SMOOTHING_ALPHA = '0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BLEND_P,
    S_BLEND_M,
    S_BLEND_R,
    S_CHECK,
    S_DIV_P,
    S_DIV_M,
    S_DIV_X,
    S_BLEND_X,
    S_OUT
  } seq_state_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } unit_op_t;

  typedef struct packed {
    logic                start;
    unit_op_t            op;
    logic [ACC_BITS-1:0] acc_init;
    logic [ACC_BITS-1:0] opd_init;
    logic [SEL_BITS-1:0] sel_init;
    logic [CNT_BITS-1:0] steps;
  } unit_cmd_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [ACC_BITS-1:0] acc;
    logic [SEL_BITS-1:0] sel;
  } unit_stat_t;

endpackage

@@ design/dit_step_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dit_step_unit: shared shift-add multiplier and restoring divider
// One wide adder serves both operations, one multiplier or quotient bit
// per cycle. Multiply: acc += sel[0] ? opd : 0, opd <<= 1, sel >>= 1.
// Divide: remainder in acc, dividend low bits shift out of sel MSB and
// quotient bits shift in at sel LSB.
// ----------------------------------------------------------------------------
module dit_step_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  dit_pkg::unit_cmd_t  cmd,
  output dit_pkg::unit_stat_t stat
);
  import dit_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  unit_op_t            op_r, op_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [ACC_BITS-1:0] acc_r, acc_nxt;
  logic [ACC_BITS-1:0] opd_r, opd_nxt;
  logic [SEL_BITS-1:0] sel_r, sel_nxt;

  logic [ACC_BITS-1:0] div_t;
  logic [ACC_BITS-1:0] add_a, add_b, add_sum;
  logic                add_cin;

  // Shared adder operand select
  always_comb begin
    div_t = {acc_r[ACC_BITS-2:0], sel_r[SEL_BITS-1]};
    if (op_r == OP_MUL) begin
      add_a   = acc_r;
      add_b   = sel_r[0] ? opd_r : '0;
      add_cin = 1'b0;
    end else begin
      add_a   = div_t;
      add_b   = ~opd_r;
      add_cin = 1'b1;
    end
    add_sum = add_a + add_b + ACC_BITS'(add_cin);
  end

  // Step control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    opd_nxt  = opd_r;
    sel_nxt  = sel_r;
    if (busy_r) begin
      cnt_nxt = cnt_r - CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      if (op_r == OP_MUL) begin
        acc_nxt = add_sum;
        opd_nxt = opd_r << 1;
        sel_nxt = sel_r >> 1;
      end else if (!add_sum[ACC_BITS-1]) begin
        acc_nxt = add_sum;
        sel_nxt = {sel_r[SEL_BITS-2:0], 1'b1};
      end else begin
        acc_nxt = div_t;
        sel_nxt = {sel_r[SEL_BITS-2:0], 1'b0};
      end
    end else if (cmd.start) begin
      busy_nxt = 1'b1;
      op_nxt   = cmd.op;
      cnt_nxt  = cmd.steps;
      acc_nxt  = cmd.acc_init;
      opd_nxt  = cmd.opd_init;
      sel_nxt  = cmd.sel_init;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    opd_r <= opd_nxt;
    sel_r <= sel_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.acc  = acc_r;
  assign stat.sel  = sel_r;

endmodule

@@ design/directional_index_tracker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// directional_index_tracker_core: ADX with exponential smoothing
// Takes one high/low/close bar per beat and returns DI+, DI- and the
// smoothed directional index in Q7.8 with a valid flag.
// ----------------------------------------------------------------------------
// Sequencing: the first bar after reset is stored and answered without any
// step unit work. Every later bar passes, from acceptance to the result
// register, through up to four 17-step blends, two 15-step DI divisions and
// one 23-step DX division, all run one bit per cycle on the single shared
// adder of dit_step_unit, plus sequencing states. A seeding bar, a saturated
// DI or a zero range skips the steps concerned. in_stall stays high from
// acceptance until the result is loaded into the output register.
// ----------------------------------------------------------------------------
module directional_index_tracker_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // bar input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dit_pkg::PRICE_BITS-1:0]    in_high_price,
  input  logic [dit_pkg::PRICE_BITS-1:0]    in_low_price,
  input  logic [dit_pkg::PRICE_BITS-1:0]    in_close_price,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dit_pkg::OUT_BITS-1:0]      out_adx_value,
  output logic [dit_pkg::OUT_BITS-1:0]      out_di_plus,
  output logic [dit_pkg::OUT_BITS-1:0]      out_di_minus,
  output logic                              out_result_valid,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dit_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import dit_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [ALPHA_BITS-1:0]   alpha_r;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic                    cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (cfg_idx == REG_SMOOTHING_ALPHA) ? 32'(alpha_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
    end else if (cfg_wr && cfg_idx == REG_SMOOTHING_ALPHA) begin
      alpha_r <= pwdata[ALPHA_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  seq_state_t             state_r, state_nxt;
  logic                   issued_r, issued_nxt;
  logic                   have_last_r, have_last_nxt;
  logic                   avg_seeded_r, avg_seeded_nxt;
  logic                   idx_seeded_r, idx_seeded_nxt;
  logic                   res_valid_r, res_valid_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [PRICE_BITS-1:0]  last_high_r, last_high_nxt;
  logic [PRICE_BITS-1:0]  last_low_r, last_low_nxt;
  logic [PRICE_BITS-1:0]  last_close_r, last_close_nxt;
  logic [PRICE_BITS-1:0]  dmp_r, dmp_nxt;
  logic [PRICE_BITS-1:0]  dmm_r, dmm_nxt;
  logic [PRICE_BITS-1:0]  tr_r, tr_nxt;
  logic [AVG_BITS-1:0]    pm_r, pm_nxt;
  logic [AVG_BITS-1:0]    mm_r, mm_nxt;
  logic [AVG_BITS-1:0]    ra_r, ra_nxt;
  logic [DI_BITS-1:0]     dip_r, dip_nxt;
  logic [DI_BITS-1:0]     dim_r, dim_nxt;
  logic [DX_BITS-1:0]     dx_r, dx_nxt;
  logic [DX_BITS-1:0]     idx_r, idx_nxt;
  logic [OUT_BITS-1:0]    adx_out_r, adx_out_nxt;
  logic [OUT_BITS-1:0]    dip_out_r, dip_out_nxt;
  logic [OUT_BITS-1:0]    dim_out_r, dim_out_nxt;
  logic                   vld_out_r, vld_out_nxt;

  logic                   in_acc;
  logic                   out_free;

  unit_cmd_t              cmd;
  unit_stat_t             stat;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // --------------------------------------------------------------------------
  // Bar front end: directional moves and true range
  // --------------------------------------------------------------------------
  logic signed [PRICE_BITS:0] up_s, down_s, t1_s, t2_s, t3_s, a2_s, a3_s, tr_s;
  logic [PRICE_BITS-1:0]      dmp_c, dmm_c;

  always_comb begin
    up_s   = $signed({1'b0, in_high_price}) - $signed({1'b0, last_high_r});
    down_s = $signed({1'b0, last_low_r}) - $signed({1'b0, in_low_price});
    dmp_c  = (up_s > down_s && up_s > 0) ? up_s[PRICE_BITS-1:0] : '0;
    dmm_c  = (down_s > up_s && down_s > 0) ? down_s[PRICE_BITS-1:0] : '0;

    t1_s = $signed({1'b0, in_high_price}) - $signed({1'b0, in_low_price});
    t2_s = $signed({1'b0, in_high_price}) - $signed({1'b0, last_close_r});
    t3_s = $signed({1'b0, in_low_price}) - $signed({1'b0, last_close_r});
    a2_s = t2_s[PRICE_BITS] ? -t2_s : t2_s;
    a3_s = t3_s[PRICE_BITS] ? -t3_s : t3_s;
    tr_s = t1_s;
    if (a2_s > tr_s) begin
      tr_s = a2_s;
    end
    if (a3_s > tr_s) begin
      tr_s = a3_s;
    end
  end

  // --------------------------------------------------------------------------
  // Step unit operand preparation
  // --------------------------------------------------------------------------
  logic [ALPHA_BITS-1:0]        alpha_eff;
  logic [BLEND_BITS-1:0]        b_old, b_val;
  logic signed [BLEND_BITS:0]   b_diff;
  logic [ACC_BITS-1:0]          blend_acc, blend_opd;
  logic [AVG_BITS-1:0]          di_num;
  logic [DI_DVD_BITS-1:0]       di_dvd;
  logic [SUM_BITS-1:0]          di_sum;
  logic [DI_BITS-1:0]           di_diff;
  logic [HUND_BITS-1:0]         diff_hund;
  logic [DX_DVD_BITS-1:0]       dx_dvd;
  logic [DX_BITS+8-1:0]         adx_round;

  always_comb begin
    alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;

    // blend old value toward new raw value
    case (state_r)
      S_BLEND_P: begin
        b_old = BLEND_BITS'(pm_r);
        b_val = BLEND_BITS'({dmp_r, {FRAC_BITS{1'b0}}});
      end
      S_BLEND_M: begin
        b_old = BLEND_BITS'(mm_r);
        b_val = BLEND_BITS'({dmm_r, {FRAC_BITS{1'b0}}});
      end
      S_BLEND_R: begin
        b_old = BLEND_BITS'(ra_r);
        b_val = BLEND_BITS'({tr_r, {FRAC_BITS{1'b0}}});
      end
      default: begin
        b_old = BLEND_BITS'(idx_r);
        b_val = BLEND_BITS'(dx_r);
      end
    endcase
    b_diff    = $signed({1'b0, b_val}) - $signed({1'b0, b_old});
    blend_acc = ACC_BITS'({b_old, {ALPHA_FRAC{1'b0}}}) + (ACC_BITS'(1) << (ALPHA_FRAC - 1));
    blend_opd = {{(ACC_BITS-BLEND_BITS-1){b_diff[BLEND_BITS]}}, b_diff};

    // DI dividend: avg * 25600 = avg * (2^14 + 2^13 + 2^10)
    di_num = (state_r == S_DIV_M) ? mm_r : pm_r;
    di_dvd = (DI_DVD_BITS'(di_num) << 14) + (DI_DVD_BITS'(di_num) << 13)
           + (DI_DVD_BITS'(di_num) << 10);

    // DX dividend: |DI+ - DI-| * 100 * 2^16
    di_sum    = SUM_BITS'(dip_r) + SUM_BITS'(dim_r);
    di_diff   = (dip_r > dim_r) ? (dip_r - dim_r) : (dim_r - dip_r);
    diff_hund = (HUND_BITS'(di_diff) << 6) + (HUND_BITS'(di_diff) << 5)
              + (HUND_BITS'(di_diff) << 2);
    dx_dvd    = {diff_hund, {INDEX_FRAC{1'b0}}};

    // Q7.16 to Q7.8 with round half up
    adx_round = (DX_BITS+8)'(idx_r) + (DX_BITS+8)'(1 << (INDEX_FRAC - 9));
  end

  // Command record for the step unit
  always_comb begin
    cmd.start = 1'b0;
    case (state_r)
      S_DIV_P, S_DIV_M: begin
        cmd.op       = OP_DIV;
        cmd.acc_init = ACC_BITS'(di_dvd >> DI_BITS);
        cmd.opd_init = ACC_BITS'(ra_r);
        cmd.sel_init = {di_dvd[DI_BITS-1:0], {(SEL_BITS-DI_BITS){1'b0}}};
        cmd.steps    = DI_STEPS;
      end
      S_DIV_X: begin
        cmd.op       = OP_DIV;
        cmd.acc_init = ACC_BITS'(dx_dvd >> DX_BITS);
        cmd.opd_init = ACC_BITS'(di_sum);
        cmd.sel_init = SEL_BITS'(dx_dvd[DX_BITS-1:0]);
        cmd.steps    = DX_STEPS;
      end
      default: begin
        cmd.op       = OP_MUL;
        cmd.acc_init = blend_acc;
        cmd.opd_init = blend_opd;
        cmd.sel_init = SEL_BITS'(alpha_eff);
        cmd.steps    = BLEND_STEPS;
      end
    endcase
    // launch once per operation state
    case (state_r)
      S_BLEND_P, S_BLEND_M, S_BLEND_R: cmd.start = !issued_r;
      S_DIV_P:   cmd.start = !issued_r && (pm_r < ra_r);
      S_DIV_M:   cmd.start = !issued_r && (mm_r < ra_r);
      S_DIV_X:   cmd.start = !issued_r && (di_sum != '0);
      S_BLEND_X: cmd.start = !issued_r && idx_seeded_r;
      default:   cmd.start = 1'b0;
    endcase
  end

  dit_step_unit u_step (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .stat (stat)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    issued_nxt     = issued_r;
    have_last_nxt  = have_last_r;
    avg_seeded_nxt = avg_seeded_r;
    idx_seeded_nxt = idx_seeded_r;
    res_valid_nxt  = res_valid_r;
    last_high_nxt  = last_high_r;
    last_low_nxt   = last_low_r;
    last_close_nxt = last_close_r;
    dmp_nxt        = dmp_r;
    dmm_nxt        = dmm_r;
    tr_nxt         = tr_r;
    pm_nxt         = pm_r;
    mm_nxt         = mm_r;
    ra_nxt         = ra_r;
    dip_nxt        = dip_r;
    dim_nxt        = dim_r;
    dx_nxt         = dx_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    adx_out_nxt    = adx_out_r;
    dip_out_nxt    = dip_out_r;
    dim_out_nxt    = dim_out_r;
    vld_out_nxt    = vld_out_r;
    if (cmd.start) begin
      issued_nxt = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          last_high_nxt  = in_high_price;
          last_low_nxt   = in_low_price;
          last_close_nxt = in_close_price;
          if (!have_last_r) begin
            have_last_nxt = 1'b1;
            res_valid_nxt = 1'b0;
            state_nxt     = S_OUT;
          end else begin
            dmp_nxt = dmp_c;
            dmm_nxt = dmm_c;
            tr_nxt  = tr_s[PRICE_BITS-1:0];
            if (avg_seeded_r) begin
              state_nxt = S_BLEND_P;
            end else begin
              // first averaged bar seeds the averages
              pm_nxt         = {dmp_c, {FRAC_BITS{1'b0}}};
              mm_nxt         = {dmm_c, {FRAC_BITS{1'b0}}};
              ra_nxt         = {tr_s[PRICE_BITS-1:0], {FRAC_BITS{1'b0}}};
              avg_seeded_nxt = 1'b1;
              state_nxt      = S_CHECK;
            end
          end
        end
      end
      S_BLEND_P: begin
        if (stat.done) begin
          pm_nxt     = stat.acc[ALPHA_FRAC +: AVG_BITS];
          issued_nxt = 1'b0;
          state_nxt  = S_BLEND_M;
        end
      end
      S_BLEND_M: begin
        if (stat.done) begin
          mm_nxt     = stat.acc[ALPHA_FRAC +: AVG_BITS];
          issued_nxt = 1'b0;
          state_nxt  = S_BLEND_R;
        end
      end
      S_BLEND_R: begin
        if (stat.done) begin
          ra_nxt     = stat.acc[ALPHA_FRAC +: AVG_BITS];
          issued_nxt = 1'b0;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        // zero range: invalid result, index average untouched
        if (ra_r == '0) begin
          res_valid_nxt = 1'b0;
          state_nxt     = S_OUT;
        end else begin
          state_nxt = S_DIV_P;
        end
      end
      S_DIV_P: begin
        if (pm_r >= ra_r) begin
          dip_nxt   = DI_FULL;
          state_nxt = S_DIV_M;
        end else if (stat.done) begin
          dip_nxt    = stat.sel[DI_BITS-1:0];
          issued_nxt = 1'b0;
          state_nxt  = S_DIV_M;
        end
      end
      S_DIV_M: begin
        if (mm_r >= ra_r) begin
          dim_nxt   = DI_FULL;
          state_nxt = S_DIV_X;
        end else if (stat.done) begin
          dim_nxt    = stat.sel[DI_BITS-1:0];
          issued_nxt = 1'b0;
          state_nxt  = S_DIV_X;
        end
      end
      S_DIV_X: begin
        if (di_sum == '0) begin
          dx_nxt    = '0;
          state_nxt = S_BLEND_X;
        end else if (stat.done) begin
          dx_nxt     = stat.sel[DX_BITS-1:0];
          issued_nxt = 1'b0;
          state_nxt  = S_BLEND_X;
        end
      end
      S_BLEND_X: begin
        if (!idx_seeded_r) begin
          // first DX seeds the index average
          idx_nxt        = dx_r;
          idx_seeded_nxt = 1'b1;
          res_valid_nxt  = 1'b1;
          state_nxt      = S_OUT;
        end else if (stat.done) begin
          idx_nxt       = stat.acc[ALPHA_FRAC +: DX_BITS];
          issued_nxt    = 1'b0;
          res_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          vld_out_nxt   = res_valid_r;
          adx_out_nxt   = res_valid_r ? adx_round[8 +: OUT_BITS] : '0;
          dip_out_nxt   = res_valid_r ? OUT_BITS'(dip_r) : '0;
          dim_out_nxt   = res_valid_r ? OUT_BITS'(dim_r) : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      issued_r     <= 1'b0;
      have_last_r  <= 1'b0;
      avg_seeded_r <= 1'b0;
      idx_seeded_r <= 1'b0;
      res_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issued_r     <= issued_nxt;
      have_last_r  <= have_last_nxt;
      avg_seeded_r <= avg_seeded_nxt;
      idx_seeded_r <= idx_seeded_nxt;
      res_valid_r  <= res_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    last_high_r  <= last_high_nxt;
    last_low_r   <= last_low_nxt;
    last_close_r <= last_close_nxt;
    dmp_r        <= dmp_nxt;
    dmm_r        <= dmm_nxt;
    tr_r         <= tr_nxt;
    pm_r         <= pm_nxt;
    mm_r         <= mm_nxt;
    ra_r         <= ra_nxt;
    dip_r        <= dip_nxt;
    dim_r        <= dim_nxt;
    dx_r         <= dx_nxt;
    idx_r        <= idx_nxt;
    adx_out_r    <= adx_out_nxt;
    dip_out_r    <= dip_out_nxt;
    dim_out_r    <= dim_out_nxt;
    vld_out_r    <= vld_out_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_adx_value    = adx_out_r;
  assign out_di_plus      = dip_out_r;
  assign out_di_minus     = dim_out_r;
  assign out_result_valid = vld_out_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTH
  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !stat.busy)
    else $error("step unit launched while busy");

  a_done_was_issued: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> issued_r)
    else $error("step unit finished an operation that was not launched");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_result_valid) |->
      (out_adx_value == '0 && out_di_plus == '0 && out_di_minus == '0))
    else $error("invalid result beat carries nonzero fields");

  a_di_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_di_plus <= DI_FULL && out_di_minus <= DI_FULL))
    else $error("DI above full scale");

  a_index_seed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(idx_seeded_r))
    else $error("index seed flag cleared outside reset");
`endif

endmodule

@@ dv/tb_directional_index_tracker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_directional_index_tracker_core: self-checking bench for the ADX tracker
// Drives price bars through the valid/stall input, predicts DI+, DI- and the
// smoothed index for each accepted bar with an integer model of the tracker,
// and checks every result beat in order. A directed table covers extremes,
// seeding, zero range, saturation and the alpha corner values; random
// phases then run price walks and noise under several alpha settings with
// idle bursts on both sides at per-phase rates; the last phase has none.
// ----------------------------------------------------------------------------
module tb_directional_index_tracker_core;

  localparam int PRICE_W        = dit_pkg::PRICE_BITS;
  localparam int OUT_W          = dit_pkg::OUT_BITS;
  localparam int PRICE_MAX      = (1 << PRICE_W) - 1;
  localparam int AVG_FRAC       = dit_pkg::FRAC_BITS;
  localparam int IDX_FRAC       = dit_pkg::INDEX_FRAC;
  localparam longint unsigned UNIT_WEIGHT = 65536;
  localparam longint unsigned DI_SCALE    = 25600;
  localparam longint unsigned DX_SCALE    = 6553600;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 95;
  localparam int SETTLE_CYCLES  = 16;
  localparam int END_CYCLES     = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_MAX     = 10;

  localparam logic [dit_pkg::CFG_ADDR_BITS-1:0] ALPHA_ADDR =
    {dit_pkg::REG_SMOOTHING_ALPHA, 2'b00};

  typedef struct packed {
    logic [OUT_W-1:0] adx;
    logic [OUT_W-1:0] di_pos;
    logic [OUT_W-1:0] di_neg;
    logic             ok;
  } dx_result_t;

  typedef enum logic {
    ROW_BAR,
    ROW_SET_ALPHA
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [PRICE_W-1:0] high;
    logic [PRICE_W-1:0] low;
    logic [PRICE_W-1:0] close;
    logic [16:0]        alpha;
    logic               typed;
    dx_result_t         res;
  } bar_row_t;

  localparam logic [OUT_W-1:0] DI_TOP       = 15'd25600;
  localparam dx_result_t       ZERO_INVALID = '0;
  localparam dx_result_t       ZERO_VALID   = '{15'd0, 15'd0, 15'd0, 1'b1};
  localparam dx_result_t       PLUS_SAT     = '{DI_TOP, DI_TOP, 15'd0, 1'b1};
  localparam dx_result_t       MINUS_SAT    = '{DI_TOP, 15'd0, DI_TOP, 1'b1};

  localparam int DIRECTED_ROWS = 21;

  // Directed stimulus; rows with typed set carry their result literally
  bar_row_t directed_rows [DIRECTED_ROWS] = '{
    // first bar only stores, then an identical bar gives DI sum zero
    '{ROW_BAR, 24'd100, 24'd50, 24'd75, 17'd0, 1'b1, ZERO_INVALID},
    '{ROW_BAR, 24'd100, 24'd50, 24'd75, 17'd0, 1'b1, ZERO_VALID},
    // price extremes, high below low
    '{ROW_BAR, 24'hFFFFFF, 24'h000000, 24'h000000, 17'd0, 1'b0, ZERO_INVALID},
    '{ROW_BAR, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 17'd0, 1'b0, ZERO_INVALID},
    '{ROW_BAR, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 17'd0, 1'b0, ZERO_INVALID},
    // alpha 1.0: averages follow raw values, so flat bars give zero range
    '{ROW_SET_ALPHA, 24'd0, 24'd0, 24'd0, 17'd65536, 1'b0, ZERO_INVALID},
    '{ROW_BAR, 24'd1000, 24'd1000, 24'd1000, 17'd0, 1'b0, ZERO_INVALID},
    '{ROW_BAR, 24'd1000, 24'd1000, 24'd1000, 17'd0, 1'b1, ZERO_INVALID},
    '{ROW_BAR, 24'd1000, 24'd1000, 24'd1500, 17'd0, 1'b1, ZERO_INVALID},
    // moves larger than the range saturate DI
    '{ROW_BAR, 24'd1510, 24'd1500, 24'd0, 17'd0, 1'b1, PLUS_SAT},
    '{ROW_BAR, 24'd10, 24'd0, 24'd0, 17'd0, 1'b1, MINUS_SAT},
    // alpha zero holds the averages
    '{ROW_SET_ALPHA, 24'd0, 24'd0, 24'd0, 17'd0, 1'b0, ZERO_INVALID},
    '{ROW_BAR, 24'd5000, 24'd4000, 24'd4500, 17'd0, 1'b0, ZERO_INVALID},
    '{ROW_SET_ALPHA, 24'd0, 24'd0, 24'd0, 17'd1, 1'b0, ZERO_INVALID},
    '{ROW_BAR, 24'd123456, 24'd120000, 24'd121000, 17'd0, 1'b0, ZERO_INVALID},
    // alpha above one acts as one
    '{ROW_SET_ALPHA, 24'd0, 24'd0, 24'd0, 17'h1FFFF, 1'b0, ZERO_INVALID},
    '{ROW_BAR, 24'd1000, 24'd1000, 24'd1000, 17'd0, 1'b0, ZERO_INVALID},
    '{ROW_BAR, 24'd1000, 24'd1000, 24'd1000, 17'd0, 1'b1, ZERO_INVALID},
    '{ROW_SET_ALPHA, 24'd0, 24'd0, 24'd0, 17'd8738, 1'b0, ZERO_INVALID},
    '{ROW_BAR, 24'hFFFFFF, 24'hFFFFFE, 24'h800000, 17'd0, 1'b0, ZERO_INVALID},
    '{ROW_BAR, 24'd0, 24'd0, 24'd0, 17'd0, 1'b0, ZERO_INVALID}
  };

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic [PRICE_W-1:0]                in_high_price;
  logic [PRICE_W-1:0]                in_low_price;
  logic [PRICE_W-1:0]                in_close_price;
  logic                              out_valid;
  logic                              out_stall;
  logic [OUT_W-1:0]                  out_adx_value;
  logic [OUT_W-1:0]                  out_di_plus;
  logic [OUT_W-1:0]                  out_di_minus;
  logic                              out_result_valid;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [dit_pkg::CFG_ADDR_BITS-1:0] paddr;
  logic [31:0]                       pwdata;
  logic [31:0]                       prdata;
  logic                              pready;

  directional_index_tracker_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_high_price    (in_high_price),
    .in_low_price     (in_low_price),
    .in_close_price   (in_close_price),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_adx_value    (out_adx_value),
    .out_di_plus      (out_di_plus),
    .out_di_minus     (out_di_minus),
    .out_result_valid (out_result_valid),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Tracker model state
  logic [16:0]        alpha_cfg;
  logic [PRICE_W-1:0] prev_high, prev_low, prev_close;
  bit                 prev_held;
  longint unsigned    plus_avg, minus_avg, range_avg;
  bit                 avg_seeded;
  longint unsigned    adx_avg;
  bit                 adx_seeded;

  // Results still owed by the block, oldest first
  dx_result_t adx_pending[$];
  dx_result_t got_beat, want_beat;

  int fail_count;
  int stall_pct;
  int gap_pct;
  bit quiet_tail;
  int walk_mid;

  // Clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  // Exponential blend, rounded half up, alpha clipped at 1.0
  function automatic longint unsigned ema(longint unsigned old, longint unsigned val);
    longint unsigned w;
    w = (alpha_cfg > UNIT_WEIGHT) ? UNIT_WEIGHT : longint'(alpha_cfg);
    return (old * (UNIT_WEIGHT - w) + val * w + 32768) >> 16;
  endfunction

  // floor(num*100%/den) in Q7.8, saturated
  function automatic longint unsigned di_ratio(longint unsigned num, longint unsigned den);
    if (num >= den) return DI_SCALE;
    return (num * DI_SCALE) / den;
  endfunction

  // One bar through the tracker model; updates the model state
  function automatic dx_result_t compute_adx_bar(logic [PRICE_W-1:0] h,
                                                 logic [PRICE_W-1:0] l,
                                                 logic [PRICE_W-1:0] c);
    longint          up_mv, dn_mv, tr, t2, t3;
    longint unsigned plus_raw, minus_raw, dip, dim, total, spread, dx;
    dx_result_t      r;
    r = '0;
    if (!prev_held) begin
      prev_high  = h;
      prev_low   = l;
      prev_close = c;
      prev_held  = 1'b1;
      return r;
    end
    up_mv     = longint'(h) - longint'(prev_high);
    dn_mv     = longint'(prev_low) - longint'(l);
    plus_raw  = (up_mv > dn_mv && up_mv > 0) ? longint'(up_mv) : 0;
    minus_raw = (dn_mv > up_mv && dn_mv > 0) ? longint'(dn_mv) : 0;
    // true range: widest of bar span and gaps to the prior close
    tr = longint'(h) - longint'(l);
    t2 = longint'(h) - longint'(prev_close);
    if (t2 < 0) t2 = -t2;
    t3 = longint'(l) - longint'(prev_close);
    if (t3 < 0) t3 = -t3;
    if (t2 > tr) tr = t2;
    if (t3 > tr) tr = t3;
    prev_high  = h;
    prev_low   = l;
    prev_close = c;
    if (avg_seeded) begin
      plus_avg  = ema(plus_avg, plus_raw << AVG_FRAC);
      minus_avg = ema(minus_avg, minus_raw << AVG_FRAC);
      range_avg = ema(range_avg, longint'(tr) << AVG_FRAC);
    end else begin
      plus_avg   = plus_raw << AVG_FRAC;
      minus_avg  = minus_raw << AVG_FRAC;
      range_avg  = longint'(tr) << AVG_FRAC;
      avg_seeded = 1'b1;
    end
    if (range_avg == 0) return r;
    dip    = di_ratio(plus_avg, range_avg);
    dim    = di_ratio(minus_avg, range_avg);
    total  = dip + dim;
    spread = (dip > dim) ? dip - dim : dim - dip;
    dx     = (total > 0) ? (spread * DX_SCALE) / total : 0;
    if (adx_seeded) begin
      adx_avg = ema(adx_avg, dx);
    end else begin
      adx_avg    = dx;
      adx_seeded = 1'b1;
    end
    r.adx    = OUT_W'((adx_avg + (64'd1 << (IDX_FRAC - 9))) >> (IDX_FRAC - 8));
    r.di_pos = OUT_W'(dip);
    r.di_neg = OUT_W'(dim);
    r.ok     = 1'b1;
    return r;
  endfunction

  function automatic logic [PRICE_W-1:0] clip_price(int v);
    if (v < 0) return '0;
    if (v > PRICE_MAX) return PRICE_W'(PRICE_MAX);
    return PRICE_W'(v);
  endfunction

  // Random bar: mostly a price walk, with noise, flat, extreme and
  // inverted bars mixed in
  task automatic make_bar(output logic [PRICE_W-1:0] h,
                          output logic [PRICE_W-1:0] l,
                          output logic [PRICE_W-1:0] c);
    int           sel, span, up_w, dn_w;
    logic [PRICE_W-1:0] tmp;
    sel = $urandom_range(0, 99);
    if (sel >= 68 && sel < 78) begin
      h = PRICE_W'($urandom_range(0, PRICE_MAX));
      l = PRICE_W'($urandom_range(0, PRICE_MAX));
      c = PRICE_W'($urandom_range(0, PRICE_MAX));
    end else if (sel >= 78 && sel < 88) begin
      h = prev_close;
      l = prev_close;
      c = prev_close;
    end else if (sel >= 88 && sel < 94) begin
      h = $urandom_range(0, 1) ? PRICE_W'(PRICE_MAX) : '0;
      l = $urandom_range(0, 1) ? PRICE_W'(PRICE_MAX) : '0;
      c = $urandom_range(0, 1) ? PRICE_W'(PRICE_MAX) : '0;
    end else begin
      if ($urandom_range(0, 49) == 0) walk_mid = int'($urandom_range(0, PRICE_MAX));
      span     = $urandom_range(0, 16);
      walk_mid = int'(clip_price(walk_mid + int'($urandom_range(0, 2 << span))
                                 - (1 << span)));
      up_w     = $urandom_range(0, 1 << $urandom_range(0, 14));
      dn_w     = $urandom_range(0, 1 << $urandom_range(0, 14));
      h        = clip_price(walk_mid + up_w);
      l        = clip_price(walk_mid - dn_w);
      c        = PRICE_W'($urandom_range(l, h));
      if (sel >= 94) begin
        tmp = h;
        h   = l;
        l   = tmp;
      end
    end
  endtask

  // Present one bar, hold it until accepted, then queue its result
  task automatic drive_bar(logic [PRICE_W-1:0] h, logic [PRICE_W-1:0] l,
                           logic [PRICE_W-1:0] c, logic typed, dx_result_t typed_res);
    dx_result_t pred;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_high_price  <= h;
    in_low_price   <= l;
    in_close_price <= c;
    do @(posedge clk); while (in_stall);
    pred = compute_adx_bar(h, l, c);
    adx_pending.insert(adx_pending.size(), typed ? typed_res : pred);
  endtask

  task automatic sender_gap(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (adx_pending.size() != 0) @(posedge clk);
  endtask

  // APB write of alpha, then read back; junk in the upper bits is dropped
  task automatic write_alpha(logic [16:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ALPHA_ADDR;
    pwdata  <= {15'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    alpha_cfg = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {15'd0, value}) begin
      note_failure($sformatf("alpha readback exp %0d got %0d", value, prdata));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result beat checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_beat = {out_adx_value, out_di_plus, out_di_minus, out_result_valid};
      if (adx_pending.size() == 0) begin
        note_failure("result beat with nothing pending");
      end else begin
        want_beat = adx_pending.pop_front();
        if (got_beat.adx !== want_beat.adx || got_beat.di_pos !== want_beat.di_pos ||
            got_beat.di_neg !== want_beat.di_neg || got_beat.ok !== want_beat.ok) begin
          note_failure($sformatf(
            "adx exp %0d got %0d, di+ exp %0d got %0d, di- exp %0d got %0d, ok exp %0d got %0d",
            want_beat.adx, got_beat.adx, want_beat.di_pos, got_beat.di_pos,
            want_beat.di_neg, got_beat.di_neg, want_beat.ok, got_beat.ok));
        end
      end
    end
  end

  // Receiver stall bursts
  initial begin : rx_stall_gen
    int n;
    out_stall = 1'b0;
    forever begin
      n = $urandom_range(1, 32);
      repeat (n) @(negedge clk) out_stall <= 1'b0;
      if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
        n = $urandom_range(1, 16);
        repeat (n) @(negedge clk) out_stall <= !quiet_tail;
      end
    end
  end

  // Watchdog on cycles without any beat
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Main sequence
  initial begin : main_seq
    int gap_plan [PHASES];
    int stall_plan [PHASES];
    logic [PRICE_W-1:0] h, l, c;
    logic [16:0] alpha_pick;
    gap_plan   = '{0, 15, 40, 10, 60, 0, 25, 5, 35, 0};
    stall_plan = '{30, 0, 40, 10, 60, 20, 0, 50, 15, 0};
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_high_price  = '0;
    in_low_price   = '0;
    in_close_price = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    fail_count     = 0;
    stall_pct      = 25;
    gap_pct        = 0;
    quiet_tail     = 1'b0;
    walk_mid       = 1 << 20;
    alpha_cfg      = 17'd8738;
    prev_high      = '0;
    prev_low       = '0;
    prev_close     = '0;
    prev_held      = 1'b0;
    plus_avg       = 0;
    minus_avg      = 0;
    range_avg      = 0;
    avg_seeded     = 1'b0;
    adx_avg        = 0;
    adx_seeded     = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, reset alpha until the first register row
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_SET_ALPHA) begin
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_alpha(directed_rows[r].alpha);
      end else begin
        if ($urandom_range(0, 2) == 0) sender_gap($urandom_range(1, 16));
        drive_bar(directed_rows[r].high, directed_rows[r].low, directed_rows[r].close,
                  directed_rows[r].typed, directed_rows[r].res);
      end
    end

    // random phases, one alpha setting each; the last runs with no idling
    for (int p = 0; p < PHASES; p++) begin
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (p)
        0:       alpha_pick = 17'd8738;
        1:       alpha_pick = 17'd65536;
        2:       alpha_pick = 17'd1;
        3:       alpha_pick = 17'd0;
        4:       alpha_pick = 17'h1FFFF;
        5:       alpha_pick = 17'($urandom_range(1, 65536));
        6:       alpha_pick = 17'($urandom_range(65537, 131071));
        7:       alpha_pick = 17'd65535;
        8:       alpha_pick = 17'($urandom_range(1000, 30000));
        default: alpha_pick = 17'($urandom_range(0, 131071));
      endcase
      write_alpha(alpha_pick);
      quiet_tail = (p == PHASES - 1);
      gap_pct    = gap_plan[p];
      stall_pct  = stall_plan[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (!quiet_tail && $urandom_range(0, 99) < gap_pct) sender_gap($urandom_range(1, 16));
        if (!quiet_tail && $urandom_range(0, 99) == 0) hold_until_drained();
        make_bar(h, l, c);
        drive_bar(h, l, c, 1'b0, ZERO_INVALID);
      end
    end

    hold_until_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (adx_pending.size() != 0) note_failure("results still pending at end of run");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/dit_pkg.sv
design/dit_step_unit.sv
design/directional_index_tracker_core.sv
dv/tb_directional_index_tracker_core.sv
